// ===== rtl/core/mqlb_pkg.sv =====
// Shared types and constants for the multi-queue linked buffer.
package mqlb_pkg;

    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic               action;
        logic [1:0]         queue_sel;
        logic signed [31:0] data_in;
    } mqlb_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data_out;
    } mqlb_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_COMMIT
    } mqlb_state_t;

    typedef struct packed {
        logic load;
        logic fetch;
        logic commit;
    } mqlb_cmd_t;

endpackage

// ===== rtl/core/multi_queue_linked_buffer_unit.sv =====
// Top level: several FIFO queues sharing one linked slot buffer.
//
//   channel   | handshake         | payload
//   ----------+-------------------+-------------------------------
//   command   | start / busy      | item   (action, queue_sel, data_in)
//   result    | done (one cycle)  | result (status, data_out)
//
// A beat is accepted, then the link and value memories are read at the free-list
// head or queue head, then it commits with at most one write to each memory; the
// result shows in the cycle after commit, when a new beat can enter.
// No clearing pass after reset: untouched slots are tracked by a high-water mark.
// The result side cannot stall; done is high for exactly one cycle per beat.
module multi_queue_linked_buffer_unit
    import mqlb_pkg::*;
#(
    parameter int SLOTS  = 16,
    parameter int QUEUES = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  mqlb_in_t  item,
    output logic      done,
    output mqlb_out_t result
);

    mqlb_cmd_t cmd;

    mqlb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    mqlb_datapath #(
        .SLOTS  (SLOTS),
        .QUEUES (QUEUES)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (item),
        .done   (done),
        .result (result)
    );

endmodule

// ===== rtl/core/mqlb_ctrl.sv =====
// Sequencer: load, fetch and commit phases of one operation.
module mqlb_ctrl
    import mqlb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    output mqlb_cmd_t cmd
);

    mqlb_state_t state_reg;
    mqlb_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:  state_next = ST_COMMIT;
            ST_COMMIT: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy       = 1'b1;
        cmd.load   = 1'b0;
        cmd.fetch  = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_FETCH:  cmd.fetch = 1'b1;
            ST_COMMIT: cmd.commit = 1'b1;
            default:   busy = 1'b1;
        endcase
    end

endmodule

// ===== rtl/core/mqlb_datapath.sv =====
// Queue pointers, free list, link and value memories, and result register.
module mqlb_datapath
    import mqlb_pkg::*;
#(
    parameter int SLOTS  = 16,
    parameter int QUEUES = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  mqlb_cmd_t cmd,
    input  mqlb_in_t  item,
    output logic      done,
    output mqlb_out_t result
);

    localparam int SW = $clog2(SLOTS);
    // queue_sel is two bits wide, so at most four queues are reachable
    localparam int NQ = (QUEUES < 4) ? QUEUES : 4;
    localparam int QW = (NQ > 1) ? $clog2(NQ) : 1;
    localparam logic [SW:0]   SLOTS_CNT = (SW + 1)'(SLOTS);
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

    // latched operation
    logic               act_reg;
    logic [QW-1:0]      q_reg;
    logic signed [31:0] data_reg;

    // queue and free-list state
    logic [SW-1:0] head_reg [NQ];
    logic [SW-1:0] head_next [NQ];
    logic [SW-1:0] tail_reg [NQ];
    logic [SW-1:0] tail_next [NQ];
    logic [NQ-1:0] nonempty_reg;
    logic [NQ-1:0] nonempty_next;
    logic [SW-1:0] free_head_reg;
    logic [SW-1:0] free_head_next;
    logic          free_empty_reg;
    logic          free_empty_next;
    logic [SW:0]   used_reg;
    logic [SW:0]   used_next;
    // slots at or above the mark were never touched and still link to slot plus one (the last slot to slot zero)
    logic [SW:0]   mark_reg;
    logic [SW:0]   mark_next;

    // memories and their read ports
    logic [SW-1:0]      link_mem [SLOTS];
    logic signed [31:0] value_mem [SLOTS];
    logic [SW-1:0]      link_rd_reg;
    logic signed [31:0] value_rd_reg;
    logic [SW-1:0]      addr_reg;
    logic               fresh_reg;

    logic [1:0]         qs;
    logic [SW-1:0]      rd_addr;
    logic [SW-1:0]      link_val;
    logic               link_we;
    logic [SW-1:0]      link_wa;
    logic [SW-1:0]      link_wd;
    logic               value_we;
    mqlb_out_t          res_next;
    mqlb_out_t          result_reg;
    logic               done_reg;

    // fold the queue number into range
    always_comb
    begin
        qs = item.queue_sel;
        for (int k = 0; k < 3; k++)
        begin
            if (int'(qs) >= QUEUES)
            begin
                qs = qs - 2'(QUEUES);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg  <= item.action;
            q_reg    <= QW'(qs);
            data_reg <= item.data_in;
        end
    end

    assign rd_addr = (act_reg == ACT_ENQ) ? free_head_reg : head_reg[q_reg];

    always_ff @(posedge clk)
    begin
        if (cmd.fetch)
        begin
            link_rd_reg  <= link_mem[rd_addr];
            addr_reg     <= rd_addr;
            fresh_reg    <= ({1'b0, rd_addr} >= mark_reg);
        end
        if (link_we)
        begin
            link_mem[link_wa] <= link_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fetch)
        begin
            value_rd_reg <= value_mem[rd_addr];
        end
        if (value_we)
        begin
            value_mem[free_head_reg] <= data_reg;
        end
    end

    assign link_val = fresh_reg ? ((addr_reg == LAST_SLOT) ? '0 : addr_reg + 1'b1)
                                : link_rd_reg;

    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        nonempty_next   = nonempty_reg;
        free_head_next  = free_head_reg;
        free_empty_next = free_empty_reg;
        used_next       = used_reg;
        mark_next       = mark_reg;
        link_we         = 1'b0;
        link_wa         = tail_reg[q_reg];
        link_wd         = free_head_reg;
        value_we        = 1'b0;
        res_next.status   = STAT_OK;
        res_next.data_out = '0;
        if (cmd.commit)
        begin
            if (act_reg == ACT_ENQ)
            begin
                if (free_empty_reg)
                begin
                    res_next.status = STAT_FULL;
                end
                else
                begin
                    used_next       = used_reg + 1'b1;
                    free_head_next  = link_val;
                    free_empty_next = (used_next >= SLOTS_CNT);
                    if (fresh_reg)
                    begin
                        mark_next = mark_reg + 1'b1;
                    end
                    // append after the current tail
                    link_we  = nonempty_reg[q_reg];
                    if (!nonempty_reg[q_reg])
                    begin
                        head_next[q_reg] = free_head_reg;
                    end
                    tail_next[q_reg]     = free_head_reg;
                    nonempty_next[q_reg] = 1'b1;
                    value_we             = 1'b1;
                end
            end
            else
            begin
                if (!nonempty_reg[q_reg])
                begin
                    res_next.status = STAT_EMPTY;
                end
                else
                begin
                    res_next.data_out = value_rd_reg;
                    if (addr_reg == tail_reg[q_reg])
                    begin
                        nonempty_next[q_reg] = 1'b0;
                    end
                    else
                    begin
                        head_next[q_reg] = link_val;
                    end
                    // push the slot back onto the free list
                    link_we         = 1'b1;
                    link_wa         = addr_reg;
                    free_head_next  = addr_reg;
                    free_empty_next = 1'b0;
                    if (used_reg != '0)
                    begin
                        used_next = used_reg - 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NQ; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
            nonempty_reg   <= '0;
            free_head_reg  <= '0;
            free_empty_reg <= 1'b0;
            used_reg       <= '0;
            mark_reg       <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            nonempty_reg   <= nonempty_next;
            free_head_reg  <= free_head_next;
            free_empty_reg <= free_empty_next;
            used_reg       <= used_next;
            mark_reg       <= mark_next;
            done_reg       <= cmd.commit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            result_reg <= res_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/core/mqlb_checker.sv =====
// Port-level checks for the multi-queue linked buffer, bound to the top level.
module mqlb_checker
    import mqlb_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input mqlb_in_t  item,
    input logic      done,
    input mqlb_out_t result
);

    // every accepted beat answers with done once its fetch and commit states have passed
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##3 done)
        else $error("result strobe missing three cycles after accept");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy && !done)
        else $error("not busy after accept");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && !$past(done))
        else $error("result strobe while busy or repeated");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == STAT_OK || result.status == STAT_FULL
                  || result.status == STAT_EMPTY))
        else $error("illegal status code");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != STAT_OK |-> result.data_out == 0)
        else $error("rejected beat carries data");

endmodule

bind multi_queue_linked_buffer_unit mqlb_checker u_mqlb_checker (.*);
